### src/cmpf_pkg.sv
// Shared constants and request types for the complex multichannel peak finder.
// No dependencies; every other file imports this package.
package cmpf_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int MAX_WINDOW   = 4096;
    localparam int SAMPLE_BITS  = 16;

    localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W      = $clog2(MAX_CHANNELS + 1);
    localparam int POS_W      = $clog2(MAX_WINDOW);
    localparam int MAG_W      = 2 * SAMPLE_BITS;
    localparam int THR_W      = 32;
    localparam int CC_W       = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT = 4'd0,
        REG_THRESHOLD_SQ  = 4'd1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_re;
        logic signed [SAMPLE_BITS-1:0] sample_im;
        logic                          window_end;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]               channel;
        logic                          has_peak;
        logic signed [SAMPLE_BITS-1:0] peak_re_out;
        logic signed [SAMPLE_BITS-1:0] peak_im_out;
        logic [POS_W-1:0]              peak_index;
        logic [CNT_W-1:0]              event_count;
        logic                          last;
    } out_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic                          window_end;
        logic [MAG_W-1:0]              mag;
    } mag_item_t;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] events;
    } snap_t;

endpackage

### src/cmpf_mag.sv
// Input register and squared-magnitude stage.
// Depends on cmpf_pkg.
module cmpf_mag
    import cmpf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output mag_item_t out_item
);

    logic      a_valid_reg;
    in_item_t  a_item_reg;
    logic      m_valid_reg;
    mag_item_t m_item_reg;

    logic                   m_advance;
    logic [SAMPLE_BITS-1:0] abs_re;
    logic [SAMPLE_BITS-1:0] abs_im;
    logic [MAG_W-1:0]       sq_re;
    logic [MAG_W-1:0]       sq_im;
    mag_item_t              m_item_next;

    assign m_advance = !m_valid_reg || out_ready;
    assign in_ready  = !a_valid_reg || m_advance;

    always_comb
    begin
        abs_re = a_item_reg.sample_re[SAMPLE_BITS-1] ?
                 (~a_item_reg.sample_re + 1'b1) : a_item_reg.sample_re;
        abs_im = a_item_reg.sample_im[SAMPLE_BITS-1] ?
                 (~a_item_reg.sample_im + 1'b1) : a_item_reg.sample_im;
        sq_re  = MAG_W'(abs_re) * MAG_W'(abs_re);
        sq_im  = MAG_W'(abs_im) * MAG_W'(abs_im);
        m_item_next.re         = a_item_reg.sample_re;
        m_item_next.im         = a_item_reg.sample_im;
        m_item_next.window_end = a_item_reg.window_end;
        m_item_next.mag        = sq_re + sq_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (m_advance)
            begin
                m_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_item_reg <= in_item;
        end
        if (m_advance && a_valid_reg)
        begin
            m_item_reg <= m_item_next;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_item  = m_item_reg;

endmodule

### src/cmpf_track.sv
// Per-channel peak tracking, channel/sample position and event count.
// Depends on cmpf_pkg; hands a window snapshot to cmpf_emit.
module cmpf_track
    import cmpf_pkg::*;
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  mag_item_t                                  in_item,
    input  logic [CNT_W-1:0]                           chan_n,
    input  logic [THR_W-1:0]                           threshold,
    input  logic                                       emit_busy,
    output snap_t                                      snap,
    output logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0]   snap_re,
    output logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0]   snap_im,
    output logic [MAX_CHANNELS-1:0][POS_W-1:0]         snap_pos,
    output logic [MAX_CHANNELS-1:0]                    snap_has
);

    logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] pk_re_reg,  pk_re_next;
    logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] pk_im_reg,  pk_im_next;
    logic [MAX_CHANNELS-1:0][MAG_W-1:0]       pk_mag_reg, pk_mag_next;
    logic [MAX_CHANNELS-1:0][POS_W-1:0]       pk_pos_reg, pk_pos_next;
    logic [CH_W-1:0]                          chan_pos_reg, chan_pos_next;
    logic [POS_W-1:0]                         sample_pos_reg, sample_pos_next;
    logic [CNT_W-1:0]                         events_reg, events_next;

    logic             take;
    logic [CH_W-1:0]  ch;
    logic [MAG_W-1:0] cur_mag;
    logic             hit;

    assign in_ready = !(in_item.window_end && emit_busy);
    assign take     = in_valid && in_ready;

    always_comb
    begin
        ch      = (CNT_W'(chan_pos_reg) >= chan_n) ? '0 : chan_pos_reg;
        cur_mag = pk_mag_reg[ch];
        hit     = (in_item.mag > cur_mag) && (in_item.mag > threshold);

        pk_re_next      = pk_re_reg;
        pk_im_next      = pk_im_reg;
        pk_mag_next     = pk_mag_reg;
        pk_pos_next     = pk_pos_reg;
        events_next     = events_reg;
        chan_pos_next   = chan_pos_reg;
        sample_pos_next = sample_pos_reg;

        if (hit)
        begin
            pk_re_next[ch]  = in_item.re;
            pk_im_next[ch]  = in_item.im;
            pk_mag_next[ch] = in_item.mag;
            pk_pos_next[ch] = sample_pos_reg;
            if (cur_mag == '0)
            begin
                events_next = events_reg + CNT_W'(1);
            end
        end

        if (CNT_W'(ch) + CNT_W'(1) >= chan_n)
        begin
            chan_pos_next = '0;
            if (sample_pos_reg != POS_W'(MAX_WINDOW - 1))
            begin
                sample_pos_next = sample_pos_reg + POS_W'(1);
            end
        end
        else
        begin
            chan_pos_next = ch + CH_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pk_re_reg      <= '0;
            pk_im_reg      <= '0;
            pk_mag_reg     <= '0;
            pk_pos_reg     <= '0;
            chan_pos_reg   <= '0;
            sample_pos_reg <= '0;
            events_reg     <= '0;
        end
        else if (take)
        begin
            if (in_item.window_end)
            begin
                pk_re_reg      <= '0;
                pk_im_reg      <= '0;
                pk_mag_reg     <= '0;
                pk_pos_reg     <= '0;
                chan_pos_reg   <= '0;
                sample_pos_reg <= '0;
                events_reg     <= '0;
            end
            else
            begin
                pk_re_reg      <= pk_re_next;
                pk_im_reg      <= pk_im_next;
                pk_mag_reg     <= pk_mag_next;
                pk_pos_reg     <= pk_pos_next;
                chan_pos_reg   <= chan_pos_next;
                sample_pos_reg <= sample_pos_next;
                events_reg     <= events_next;
            end
        end
    end

    always_comb
    begin
        snap.valid  = take && in_item.window_end;
        snap.count  = chan_n;
        snap.events = events_next;
        snap_re     = pk_re_next;
        snap_im     = pk_im_next;
        snap_pos    = pk_pos_next;
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            snap_has[i] = (pk_mag_next[i] != '0);
        end
    end

endmodule

### src/cmpf_emit.sv
// Window result bank, per-channel result sequencer and output register.
// Depends on cmpf_pkg; loaded from cmpf_track at window end.
module cmpf_emit
    import cmpf_pkg::*;
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  snap_t                                    snap,
    input  logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] snap_re,
    input  logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] snap_im,
    input  logic [MAX_CHANNELS-1:0][POS_W-1:0]       snap_pos,
    input  logic [MAX_CHANNELS-1:0]                  snap_has,
    output logic                                     busy,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output out_item_t                                out_item
);

    logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] bank_re_reg;
    logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] bank_im_reg;
    logic [MAX_CHANNELS-1:0][POS_W-1:0]       bank_pos_reg;
    logic [MAX_CHANNELS-1:0]                  bank_has_reg;
    logic [CNT_W-1:0]                         bank_n_reg;
    logic [CNT_W-1:0]                         bank_events_reg;

    logic            active_reg;
    logic [CH_W-1:0] idx_reg;
    logic            out_valid_reg;
    out_item_t       out_item_reg;

    logic      load;
    logic      is_last;
    out_item_t out_item_next;

    assign load    = active_reg && (!out_valid_reg || out_ready);
    assign is_last = (CNT_W'(idx_reg) + CNT_W'(1) == bank_n_reg);

    always_comb
    begin
        out_item_next.channel     = idx_reg;
        out_item_next.has_peak    = bank_has_reg[idx_reg];
        out_item_next.peak_re_out = bank_re_reg[idx_reg];
        out_item_next.peak_im_out = bank_im_reg[idx_reg];
        out_item_next.peak_index  = bank_pos_reg[idx_reg];
        out_item_next.event_count = bank_events_reg;
        out_item_next.last        = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (snap.valid)
            begin
                active_reg <= 1'b1;
                idx_reg    <= '0;
            end
            else if (load)
            begin
                if (is_last)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + CH_W'(1);
                end
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap.valid)
        begin
            bank_re_reg     <= snap_re;
            bank_im_reg     <= snap_im;
            bank_pos_reg    <= snap_pos;
            bank_has_reg    <= snap_has;
            bank_n_reg      <= snap.count;
            bank_events_reg <= snap.events;
        end
        if (load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // bank frees up in the cycle its final result moves to the output register
    assign busy      = active_reg && !(load && is_last);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### src/complex_multichannel_peak_finder.sv
// Top level of the complex multichannel peak finder: config registers and stage wiring.
// Depends on cmpf_pkg, cmpf_mag, cmpf_track and cmpf_emit.
//
//   channel | handshake                  | moves
//   --------+----------------------------+---------------------------------------
//   sample  | sample_valid/sample_ready  | one complex sample request, in_item_t
//   result  | result_valid/result_ready  | one per-channel result request, out_item_t
//   cfg     | cfg_valid/cfg_ready        | register write: cfg_index, cfg_data
//
// One sample per cycle unless stalled; a sample passes the input register and the magnitude register
// before the tracker, which hands its window snapshot to the result bank. A window-end sample stalls in
// the tracker while the previous window is still being emitted (one result per cycle, channel count
// results, paced by result_ready). Reset clears all peaks, positions and counters; channel_count resets to 1.
// cfg_ready is always high; writes are expected only while no request is in flight.
module complex_multichannel_peak_finder
    import cmpf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  in_item_t              sample,
    output logic                  result_valid,
    input  logic                  result_ready,
    output out_item_t             result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CC_W-1:0]  channel_count_reg;
    logic [THR_W-1:0] threshold_sq_reg;
    logic [CNT_W-1:0] chan_n;

    logic      m_valid;
    logic      m_ready;
    mag_item_t m_item;

    snap_t                                    snap;
    logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] snap_re;
    logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] snap_im;
    logic [MAX_CHANNELS-1:0][POS_W-1:0]       snap_pos;
    logic [MAX_CHANNELS-1:0]                  snap_has;
    logic                                     emit_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CC_W'(1);
            threshold_sq_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_CHANNEL_COUNT)
            begin
                channel_count_reg <= cfg_data[CC_W-1:0];
            end
            else if (cfg_index == REG_THRESHOLD_SQ)
            begin
                threshold_sq_reg <= cfg_data[THR_W-1:0];
            end
        end
    end

    // zero acts as one, oversize clamps to the channel capacity
    always_comb
    begin
        if (channel_count_reg == '0)
        begin
            chan_n = CNT_W'(1);
        end
        else if (int'(channel_count_reg) > MAX_CHANNELS)
        begin
            chan_n = CNT_W'(MAX_CHANNELS);
        end
        else
        begin
            chan_n = CNT_W'(channel_count_reg);
        end
    end

    cmpf_mag u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_valid),
        .in_ready  (sample_ready),
        .in_item   (sample),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_item)
    );

    cmpf_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid),
        .in_ready  (m_ready),
        .in_item   (m_item),
        .chan_n    (chan_n),
        .threshold (threshold_sq_reg),
        .emit_busy (emit_busy),
        .snap      (snap),
        .snap_re   (snap_re),
        .snap_im   (snap_im),
        .snap_pos  (snap_pos),
        .snap_has  (snap_has)
    );

    cmpf_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .snap      (snap),
        .snap_re   (snap_re),
        .snap_im   (snap_im),
        .snap_pos  (snap_pos),
        .snap_has  (snap_has),
        .busy      (emit_busy),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_item  (result)
    );

endmodule

### test/complex_multichannel_peak_finder_tb.sv
// Self-checking testbench for complex_multichannel_peak_finder: a directed table, then
// a long receiver stall and random windows.
// Depends on cmpf_pkg and the complex_multichannel_peak_finder RTL.
module complex_multichannel_peak_finder_tb;
    import cmpf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 255;
    localparam int DRAIN_CYCLES = 8;
    localparam int END_CYCLES   = 32;
    localparam int LONG_HOLD    = 400;
    localparam int LIMIT_CYCLES = 400000;

    typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;
    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_TOGGLE} sink_mode_t;

    typedef struct {
        row_kind_t  kind;
        logic [4:0] chans;
        logic [31:0] thresh;
        in_item_t   item;
        bit         typed;
        out_item_t  want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_ready;
    in_item_t              sample;
    logic                  result_valid;
    logic                  result_ready;
    out_item_t             result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state
    logic signed [SAMPLE_BITS-1:0] pk_re [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] pk_im [MAX_CHANNELS];
    logic [MAG_W-1:0]              pk_mag [MAX_CHANNELS];
    logic [POS_W-1:0]              pk_idx [MAX_CHANNELS];
    int                            cur_chan;
    int                            cur_pos;
    int                            chans_hit;
    logic [4:0]                    cfg_chans;
    logic [31:0]                   cfg_thresh;

    out_item_t   pending_peaks[$];
    dir_row_t    dir_rows[$];
    int          mismatches = 0;
    int unsigned cycles = 0;
    int          burst_left;
    bit          gaps_on;
    bit          hold_off_req;

    complex_multichannel_peak_finder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int active_chans(input logic [4:0] chans);
        if (chans == 0)
            return 1;
        if (chans > MAX_CHANNELS)
            return MAX_CHANNELS;
        return int'(chans);
    endfunction

    function automatic void clear_window_peaks();
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            pk_re[c]  = '0;
            pk_im[c]  = '0;
            pk_mag[c] = '0;
            pk_idx[c] = '0;
        end
        cur_chan  = 0;
        cur_pos   = 0;
        chans_hit = 0;
    endfunction

    // Track one sample; at window end queue one result per channel in use when keep is set.
    function automatic void find_peaks(input in_item_t item, input bit keep);
        logic [15:0] ar;
        logic [15:0] ai;
        logic [32:0] mag;
        int          n;
        int          ch;
        out_item_t   r;
        n  = active_chans(cfg_chans);
        ar = item.sample_re;
        if (ar[15])
            ar = ~ar + 16'd1;
        ai = item.sample_im;
        if (ai[15])
            ai = ~ai + 16'd1;
        mag = ar * ar + ai * ai;
        if (cur_chan >= n)
            cur_chan = 0;
        ch = cur_chan;
        if (mag > pk_mag[ch] && mag > cfg_thresh)
        begin
            if (pk_mag[ch] == 0)
                chans_hit++;
            pk_re[ch]  = item.sample_re;
            pk_im[ch]  = item.sample_im;
            pk_mag[ch] = mag[MAG_W-1:0];
            pk_idx[ch] = POS_W'(cur_pos);
        end
        if (cur_chan + 1 >= n)
        begin
            cur_chan = 0;
            if (cur_pos < MAX_WINDOW - 1)
                cur_pos++;
        end
        else
            cur_chan++;
        if (!item.window_end)
            return;
        for (ch = 0; ch < n; ch++)
        begin
            r.channel     = CH_W'(ch);
            r.has_peak    = (pk_mag[ch] != 0);
            r.peak_re_out = r.has_peak ? pk_re[ch] : '0;
            r.peak_im_out = r.has_peak ? pk_im[ch] : '0;
            r.peak_index  = r.has_peak ? pk_idx[ch] : '0;
            r.event_count = CNT_W'(chans_hit);
            r.last        = (ch == n - 1);
            if (keep)
                pending_peaks.push_back(r);
        end
        clear_window_peaks();
    endfunction

    function automatic dir_row_t cfg_row(input logic [4:0] chans, input logic [31:0] thresh);
        dir_row_t r;
        r = '{kind: ROW_CONFIG, chans: chans, thresh: thresh, item: '0, typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic dir_row_t sample_row(input int re, input int im, input bit wend);
        dir_row_t r;
        r = '{kind: ROW_SAMPLE, chans: '0, thresh: '0, item: '0, typed: 1'b0, want: '0};
        r.item.sample_re  = 16'(re);
        r.item.sample_im  = 16'(im);
        r.item.window_end = wend;
        return r;
    endfunction

    // Single-channel window end with its result written out by hand.
    function automatic dir_row_t typed_row(input int re, input int im, input bit has,
                                           input int pre, input int pim, input int ev);
        dir_row_t r;
        r = sample_row(re, im, 1'b1);
        r.typed            = 1'b1;
        r.want.channel     = '0;
        r.want.has_peak    = has;
        r.want.peak_re_out = 16'(pre);
        r.want.peak_im_out = 16'(pim);
        r.want.peak_index  = '0;
        r.want.event_count = CNT_W'(ev);
        r.want.last        = 1'b1;
        return r;
    endfunction

    function automatic logic [15:0] corner_value();
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic in_item_t random_sample(input bit wend);
        in_item_t it;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                it.sample_re = 16'($urandom);
                it.sample_im = 16'($urandom);
            end
            4, 5, 6:
            begin
                it.sample_re = 16'($urandom_range(0, 127)) - 16'd64;
                it.sample_im = 16'($urandom_range(0, 127)) - 16'd64;
            end
            7, 8:
            begin
                it.sample_re = corner_value();
                it.sample_im = corner_value();
            end
            default:
            begin
                it.sample_re = 16'($urandom);
                it.sample_im = '0;
            end
        endcase
        it.window_end = wend;
        return it;
    endfunction

    task automatic send_sample(input in_item_t item, input bit typed, input out_item_t want);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
            begin
                sample_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        sample_valid <= 1'b1;
        sample       <= item;
        do
            @(posedge clk);
        while (!sample_ready);
        find_peaks(item, !typed);
        if (typed)
            pending_peaks.push_back(want);
        @(negedge clk);
    endtask

    task automatic settle();
        sample_valid <= 1'b0;
        while (pending_peaks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(input logic [4:0] chans, input logic [31:0] thresh);
        cfg_valid <= 1'b1;
        cfg_index <= REG_CHANNEL_COUNT;
        cfg_data  <= CFG_DATA_W'(chans);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_chans = chans;
        @(negedge clk);
        cfg_index <= REG_THRESHOLD_SQ;
        cfg_data  <= thresh;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_thresh = thresh;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : result_sink
        sink_mode_t mode;
        int         span;
        int         held;
        bit         hold_done;
        result_ready = 1'b0;
        mode         = SINK_OPEN;
        span         = 0;
        hold_done    = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_done)
            begin
                hold_done = 1'b1;
                result_ready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++)
                    @(negedge clk);
            end
            if (span == 0)
            begin
                mode = sink_mode_t'($urandom_range(0, 3));
                span = $urandom_range(20, 120);
            end
            span--;
            case (mode)
                SINK_OPEN:   result_ready <= 1'b1;
                SINK_COIN:   result_ready <= 1'($urandom_range(0, 1));
                SINK_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
                default:     result_ready <= ~result_ready;
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_peaks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("extra: ch %0d has %0d re %0d im %0d idx %0d ev %0d last %0d",
                             result.channel, result.has_peak, result.peak_re_out,
                             result.peak_im_out, result.peak_index, result.event_count,
                             result.last);
            end
            else
            begin
                want = pending_peaks.pop_front();
                if (want.channel !== result.channel || want.has_peak !== result.has_peak
                    || want.peak_re_out !== result.peak_re_out
                    || want.peak_im_out !== result.peak_im_out
                    || want.peak_index !== result.peak_index
                    || want.event_count !== result.event_count || want.last !== result.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("exp ch %0d has %0d re %0d im %0d idx %0d ev %0d last %0d",
                                 want.channel, want.has_peak, want.peak_re_out, want.peak_im_out,
                                 want.peak_index, want.event_count, want.last);
                        $display("got ch %0d has %0d re %0d im %0d idx %0d ev %0d last %0d",
                                 result.channel, result.has_peak, result.peak_re_out,
                                 result.peak_im_out, result.peak_index, result.event_count,
                                 result.last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          w;
        int          i;
        int          n;
        int          len;
        int          total;
        int          windows;
        int          random_items;
        bit          open_end;
        bit          wend;
        logic [4:0]  chans;
        logic [31:0] thresh;

        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_CHANNEL_COUNT;
        cfg_data     = '0;
        burst_left   = 0;
        gaps_on      = 1'b1;
        hold_off_req = 1'b0;
        random_items = 0;
        clear_window_peaks();
        cfg_chans  = 5'd1;
        cfg_thresh = '0;

        dir_rows.push_back(cfg_row(5'd1, 32'd0));
        dir_rows.push_back(typed_row(0, 0, 1'b0, 0, 0, 0));
        dir_rows.push_back(typed_row(-32768, -32768, 1'b1, -32768, -32768, 1));
        dir_rows.push_back(sample_row(32767, 0, 1'b0));
        dir_rows.push_back(typed_row(1, 1, 1'b1, 32767, 0, 1));
        // equal magnitude later in the window: the first sample stays
        dir_rows.push_back(sample_row(0, 1, 1'b0));
        dir_rows.push_back(typed_row(-1, 0, 1'b1, 0, 1, 1));
        // zero channel count acts as one; threshold at the largest magnitude
        dir_rows.push_back(cfg_row(5'd0, 32'h8000_0000));
        dir_rows.push_back(typed_row(-32768, -32768, 1'b0, 0, 0, 0));
        dir_rows.push_back(cfg_row(5'd0, 32'h7FFF_FFFF));
        dir_rows.push_back(typed_row(-32768, -32768, 1'b1, -32768, -32768, 1));
        dir_rows.push_back(cfg_row(5'd3, 32'd100));
        dir_rows.push_back(sample_row(10, 0, 1'b0));
        dir_rows.push_back(sample_row(0, 11, 1'b0));
        dir_rows.push_back(sample_row(-20, 5, 1'b0));
        dir_rows.push_back(sample_row(11, 0, 1'b0));
        dir_rows.push_back(sample_row(-5, -5, 1'b0));
        // count lowered mid-window: channel 2 peak stays counted but is not reported
        dir_rows.push_back(cfg_row(5'd2, 32'd100));
        dir_rows.push_back(sample_row(-30, 0, 1'b1));
        dir_rows.push_back(cfg_row(5'd31, 32'hFFFF_FFFF));
        dir_rows.push_back(sample_row(32767, -32768, 1'b0));
        dir_rows.push_back(sample_row(-32768, 32767, 1'b1));
        dir_rows.push_back(cfg_row(5'd16, 32'd0));
        dir_rows.push_back(sample_row(32767, 32767, 1'b0));
        dir_rows.push_back(sample_row(-1, -1, 1'b0));
        dir_rows.push_back(sample_row(0, -32768, 1'b1));

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].kind == ROW_CONFIG)
            begin
                settle();
                write_config(dir_rows[k].chans, dir_rows[k].thresh);
            end
            else
                send_sample(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
        end

        // back pressure: sink holds off while full windows keep arriving
        settle();
        write_config(5'd16, 32'd0);
        gaps_on      = 1'b0;
        hold_off_req = 1'b1;
        for (w = 0; w < 6; w++)
            for (i = 0; i < MAX_CHANNELS; i++)
                send_sample(random_sample(i == MAX_CHANNELS - 1), 1'b0, '0);

        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            case ($urandom_range(0, 9))
                0: chans = 5'd0;
                1: chans = 5'($urandom_range(17, 31));
                2: chans = 5'd16;
                3, 4, 5: chans = 5'($urandom_range(1, 4));
                default: chans = 5'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 7))
                0: thresh = 32'd0;
                1: thresh = $urandom_range(0, 4096);
                2: thresh = $urandom;
                3: thresh = 32'h8000_0000;
                4: thresh = 32'h7FFF_FFFF;
                5: thresh = 32'hFFFF_FFFF;
                default: thresh = $urandom_range(0, 32'h0100_0000);
            endcase
            write_config(chans, thresh);
            n       = active_chans(chans);
            gaps_on = ($urandom_range(0, 3) != 0);
            windows = $urandom_range(1, 4);
            for (w = 0; w < windows; w++)
            begin
                len   = (n > 4) ? $urandom_range(1, 3) : $urandom_range(1, 12);
                total = len * n;
                if ($urandom_range(0, 7) == 0)
                    total = $urandom_range(1, total);
                open_end = (w == windows - 1) && ($urandom_range(0, 3) == 0);
                for (i = 0; i < total; i++)
                begin
                    wend = ((i == total - 1) && !open_end) || ($urandom_range(0, 40) == 0);
                    send_sample(random_sample(wend), 1'b0, '0);
                    random_items++;
                end
            end
        end

        sample_valid <= 1'b0;
        while (pending_peaks.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_peaks.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
